// ----- rtl/tlvp_pkg.sv -----
// Types and constants shared by the TLV message parser.
// Holds the item structs, the parser state struct and the event and status codes.
// No dependencies.
package tlvp_pkg;

	typedef enum logic [1:0] {
		PH_HEADER    = 2'd0,
		PH_FIELD_HDR = 2'd1,
		PH_VALUE     = 2'd2,
		PH_IGNORE    = 2'd3
	} phase_t;

	localparam logic [1:0] EV_NONE       = 2'd0;
	localparam logic [1:0] EV_HEADER     = 2'd1;
	localparam logic [1:0] EV_FIELD_HDR  = 2'd2;
	localparam logic [1:0] EV_VALUE      = 2'd3;

	localparam logic [2:0] ST_IN_PROGRESS = 3'd0;
	localparam logic [2:0] ST_SUCCESS     = 3'd1;
	localparam logic [2:0] ST_SHORT_BUF   = 3'd2;
	localparam logic [2:0] ST_TOO_MANY    = 3'd3;
	localparam logic [2:0] ST_TRUNCATED   = 3'd4;

	localparam logic [1:0] SUB_LAST = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [7:0]  type_byte;
		logic [7:0]  cmd_byte;
		logic [7:0]  num_fields;
		logic [7:0]  field_index;
		logic [15:0] field_tag;
		logic [15:0] field_length;
		logic [7:0]  value_byte;
		logic        value_last;
		logic [2:0]  status;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  sub_byte_count;
		logic [7:0]  current_field;
		logic [7:0]  held_type;
		logic [7:0]  held_command;
		logic [7:0]  held_count;
		logic [15:0] held_tag;
		logic [15:0] held_length;
		logic [15:0] value_left;
	} parser_state_t;

endpackage

// ----- rtl/tlvp_step.sv -----
// One parse step of the TLV message parser: next state and result for one byte.
// Purely combinational; depends on tlvp_pkg.
module tlvp_step #(
	parameter int MAX_FIELDS = 16
) (
	input  tlvp_pkg::parser_state_t cur,
	input  tlvp_pkg::in_item_t      item,
	output tlvp_pkg::parser_state_t nxt,
	output tlvp_pkg::out_item_t     result
);
	import tlvp_pkg::*;

	localparam logic [7:0] MaxCount = 8'(MAX_FIELDS);

	logic [7:0] b;
	logic       end_flag;
	logic       last_field;
	logic       active;
	logic [1:0] kind;
	logic [2:0] status;
	logic [7:0] vb;
	logic       vlast;
	logic [7:0] idx;
	logic [15:0] new_length;

	assign b          = item.data_byte;
	assign end_flag   = item.buffer_end;
	assign last_field = ({1'b0, cur.current_field} + 9'd1) >= {1'b0, cur.held_count};
	assign new_length = {cur.held_length[15:8], b};

	always_comb begin
		nxt    = cur;
		kind   = EV_NONE;
		status = ST_IN_PROGRESS;
		vb     = 8'd0;
		vlast  = 1'b0;
		idx    = cur.current_field;
		active = 1'b1;
		case (cur.phase)
			PH_HEADER: begin
				case (cur.sub_byte_count)
					2'd0: begin
						// first byte of a message: drop everything held from the last one
						nxt.held_type     = b;
						nxt.held_command  = 8'd0;
						nxt.held_count    = 8'd0;
						nxt.held_tag      = 16'd0;
						nxt.held_length   = 16'd0;
						nxt.value_left    = 16'd0;
						nxt.current_field = 8'd0;
						idx               = 8'd0;
					end
					2'd1: nxt.held_command = b;
					2'd2: nxt.held_count = b;
					default: ;
				endcase
				if (cur.sub_byte_count != SUB_LAST) begin
					nxt.sub_byte_count = cur.sub_byte_count + 2'd1;
					if (end_flag) begin
						status = ST_SHORT_BUF;
					end
				end else begin
					kind               = EV_HEADER;
					nxt.sub_byte_count = 2'd0;
					if (cur.held_count > MaxCount) begin
						status = ST_TOO_MANY;
					end else if (cur.held_count == 8'd0) begin
						status = ST_SUCCESS;
					end else begin
						nxt.phase = PH_FIELD_HDR;
					end
				end
			end
			PH_FIELD_HDR: begin
				case (cur.sub_byte_count)
					2'd0: nxt.held_tag = {b, 8'd0};
					2'd1: nxt.held_tag = {cur.held_tag[15:8], b};
					2'd2: nxt.held_length = {b, 8'd0};
					default: nxt.held_length = new_length;
				endcase
				if (cur.sub_byte_count != SUB_LAST) begin
					nxt.sub_byte_count = cur.sub_byte_count + 2'd1;
				end else begin
					kind               = EV_FIELD_HDR;
					nxt.sub_byte_count = 2'd0;
					if (new_length == 16'd0) begin
						// empty field completes with its header
						if (last_field) begin
							status = ST_SUCCESS;
						end else begin
							nxt.current_field = cur.current_field + 8'd1;
							nxt.phase         = PH_FIELD_HDR;
						end
					end else begin
						nxt.value_left = new_length;
						nxt.phase      = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				kind = EV_VALUE;
				vb   = b;
				if (cur.value_left <= 16'd1) begin
					vlast          = 1'b1;
					nxt.value_left = 16'd0;
					if (last_field) begin
						status = ST_SUCCESS;
					end else begin
						nxt.current_field  = cur.current_field + 8'd1;
						nxt.phase          = PH_FIELD_HDR;
						nxt.sub_byte_count = 2'd0;
					end
				end else begin
					nxt.value_left = cur.value_left - 16'd1;
				end
			end
			default: begin
				active = 1'b0;
				if (end_flag) begin
					nxt.phase          = PH_HEADER;
					nxt.sub_byte_count = 2'd0;
				end
			end
		endcase

		if (active) begin
			if (status == ST_IN_PROGRESS && end_flag) begin
				status = ST_TRUNCATED;
			end
			if (status != ST_IN_PROGRESS) begin
				nxt.phase          = end_flag ? PH_HEADER : PH_IGNORE;
				nxt.sub_byte_count = 2'd0;
			end
		end

		result.event_kind   = kind;
		result.type_byte    = nxt.held_type;
		result.cmd_byte     = nxt.held_command;
		result.num_fields   = nxt.held_count;
		result.field_index  = idx;
		result.field_tag    = nxt.held_tag;
		result.field_length = nxt.held_length;
		result.value_byte   = vb;
		result.value_last   = vlast;
		result.status       = status;
	end

endmodule

// ----- rtl/tlv_message_parser.sv -----
// TLV message parser, top level.
// Depends on tlvp_pkg and tlvp_step.
//
// Usage:
//   The item channel (item_valid, item_ready, item) carries one buffer byte and
//   its buffer_end mark. The result channel (result_valid, result_ready, result)
//   returns exactly one result item for every byte accepted, in order.
//   A message is a 4-byte header (type, command tag, field count, reserved)
//   followed by the declared fields, each a 16-bit tag, a 16-bit length and the
//   value bytes, all big-endian.
// Timing and throughput:
//   The result of a byte is registered and presented in the cycle after the byte is accepted.
//   One byte is taken every cycle unless the result channel stalls; the parse step is a single pass of logic
//   from the parser state and the incoming byte into the result register.
// Reset:
//   arst_n clears the parser to the start of a header and empties the result
//   register.
// Stalls:
//   While result_ready is low with a result held, item_ready drops and the
//   parser state holds; the next byte is taken in the cycle the result leaves.
module tlv_message_parser #(
	parameter int MAX_FIELDS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  tlvp_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output tlvp_pkg::out_item_t result
);
	import tlvp_pkg::*;

	parser_state_t state_q;
	parser_state_t state_nxt;
	out_item_t     step_result;
	out_item_t     result_q;
	logic          result_valid_q;
	logic          accept;

	tlvp_step #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_step (
		.cur   (state_q),
		.item  (item),
		.nxt   (state_nxt),
		.result(step_result)
	);

	assign item_ready   = !result_valid_q || result_ready;
	assign accept       = item_valid && item_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			// hold the result until taken; refill in the same cycle it leaves
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= step_result;
		end
	end

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> item_ready)
		else $error("item_ready low with empty result register");

	a_end_leaves_message: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && step_result.status != ST_IN_PROGRESS) |=>
		(state_q.phase == PH_HEADER || state_q.phase == PH_IGNORE))
		else $error("parser still inside a message after final status");

	a_sub_zero_outside_headers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_VALUE || state_q.phase == PH_IGNORE) |->
		state_q.sub_byte_count == 2'd0)
		else $error("byte position not cleared outside header phases");

	a_last_only_on_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.value_last) |-> result_q.event_kind == EV_VALUE)
		else $error("value_last set on a non-value result");

	a_field_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_VALUE || state_q.phase == PH_FIELD_HDR) |->
		state_q.current_field < state_q.held_count)
		else $error("field index beyond declared field count");

endmodule
